>>> src/indexed_list_insert_remove_assert.svh
// Assertion macros for the indexed list block.
// Used by the top level only; clock aclk and reset aresetn are assumed in scope.
`ifndef INDEXED_LIST_INSERT_REMOVE_ASSERT_SVH
`define INDEXED_LIST_INSERT_REMOVE_ASSERT_SVH
`ifndef SYNTHESIS
`define ILIR_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);
`define ILIR_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define ILIR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ILIR_ASSERT_NEVER(lbl, cond, msg)
`define ILIR_ASSERT_IMPLY(lbl, ante, cons, msg)
`define ILIR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> src/ilir_pkg.sv
// Shared constants, command and cell operation codes, and the cell control struct.
// No dependencies.
`default_nettype none
package ilir_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    localparam int WORD_W  = 32;
    localparam int CMD_W   = 2;
    localparam int POS_W   = 6;
    localparam int WHERE_W = 5;
    localparam int COUNT_W = 6;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_HOLD = 3'd0;
    localparam logic [OP_W-1:0] OP_CMP  = 3'd1;
    localparam logic [OP_W-1:0] OP_INS  = 3'd2;
    localparam logic [OP_W-1:0] OP_REM  = 3'd3;
    localparam logic [OP_W-1:0] OP_WR   = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  sel;
        logic [WORD_W-1:0] value;
        logic [CNT_W-1:0]  count;
    } ilir_ctrl_t;

endpackage
`default_nettype wire

>>> src/indexed_list_insert_remove.sv
// A new command is accepted only in IDLE, so the block takes no new command before the
// last one has left EXEC: the cell row compares all entries in the accept cycle, then
// shifts, writes or reads in the next, where the result is registered; a held result stalls that step.
// Reset: entry count cleared to zero, result channel empty; entries are not cleared.
// Depends on ilir_pkg, ilir_cell and indexed_list_insert_remove_assert.svh.
`default_nettype none
`include "indexed_list_insert_remove_assert.svh"
module indexed_list_insert_remove (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [ilir_pkg::CMD_W-1:0]         s_cmd,
    input  wire logic signed [ilir_pkg::WORD_W-1:0] s_value,
    input  wire logic [ilir_pkg::POS_W-1:0]         s_position,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_ok,
    output logic [ilir_pkg::WHERE_W-1:0]            m_where,
    output logic [ilir_pkg::COUNT_W-1:0]            m_count,
    output logic signed [ilir_pkg::WORD_W-1:0]      m_read_value
);
    import ilir_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic              state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CMD_W-1:0]  cmd_reg;
    logic [WORD_W-1:0] value_reg;
    logic [POS_W-1:0]  pos_reg;

    logic                      m_valid_reg, m_valid_next;
    logic                      m_ok_reg;
    logic [WHERE_W-1:0]        m_where_reg;
    logic [COUNT_W-1:0]        m_count_reg;
    logic signed [WORD_W-1:0]  m_read_value_reg;

    ilir_ctrl_t        ctrl;
    logic [WORD_W-1:0] entry_vec [LIST_DEPTH];
    logic [WORD_W-1:0] left_vec  [LIST_DEPTH];
    logic [WORD_W-1:0] right_vec [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] match_vec;

    logic                  s_fire, done, ok, full, found;
    logic [IDX_W-1:0]      hit, widx;
    logic [OP_W-1:0]       exec_op;
    logic [CNT_W-1:0]      cnt_new;
    logic [WORD_W-1:0]     rd;
    logic [CNT_W+POS_W-1:0] pos_ext, cnt_ext;

    genvar g;
    generate
        for (g = 0; g < LIST_DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign left_vec[g] = entry_vec[g];
            end else begin : g_mid_l
                assign left_vec[g] = entry_vec[g-1];
            end
            if (g == LIST_DEPTH - 1) begin : g_last
                assign right_vec[g] = entry_vec[g];
            end else begin : g_mid_r
                assign right_vec[g] = entry_vec[g+1];
            end
            ilir_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .cell_idx    (IDX_W'(g)),
                .ctrl        (ctrl),
                .left_entry  (left_vec[g]),
                .right_entry (right_vec[g]),
                .entry       (entry_vec[g]),
                .match       (match_vec[g])
            );
        end
    endgenerate

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign done    = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);

    // first matching cell
    always_comb begin
        hit = '0;
        for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
            if (match_vec[i]) begin
                hit = IDX_W'(i);
            end
        end
    end

    assign found   = |match_vec;
    assign full    = (count_reg == CNT_W'(LIST_DEPTH));
    assign pos_ext = {{CNT_W{1'b0}}, pos_reg};
    assign cnt_ext = {{POS_W{1'b0}}, count_reg};

    always_comb begin
        ok      = 1'b0;
        widx    = '0;
        exec_op = OP_HOLD;
        cnt_new = count_reg;
        rd      = '0;
        unique case (cmd_reg)
            CMD_INSERT: begin
                ok      = !full && (pos_ext <= cnt_ext);
                widx    = IDX_W'(pos_reg);
                exec_op = OP_INS;
                cnt_new = count_reg + CNT_W'(1);
            end
            CMD_REMOVE: begin
                ok      = found;
                widx    = hit;
                exec_op = OP_REM;
                cnt_new = count_reg - CNT_W'(1);
            end
            CMD_APPEND: begin
                ok      = !full;
                widx    = count_reg[IDX_W-1:0];
                exec_op = OP_WR;
                cnt_new = count_reg + CNT_W'(1);
            end
            CMD_READ: begin
                ok      = (pos_ext < cnt_ext);
                widx    = IDX_W'(pos_reg);
                exec_op = OP_HOLD;
                if (ok) begin
                    rd = entry_vec[widx];
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        ctrl.op    = OP_HOLD;
        ctrl.sel   = widx;
        ctrl.value = value_reg;
        ctrl.count = count_reg;
        if (state_reg == ST_IDLE) begin
            ctrl.value = unsigned'(s_value);
            if (s_fire) begin
                ctrl.op = OP_CMP;
            end
        end else if (done && ok) begin
            ctrl.op = exec_op;
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (done) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    if (ok) begin
                        count_next = cnt_new;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg   <= s_cmd;
            value_reg <= unsigned'(s_value);
            pos_reg   <= s_position;
        end
        if (done) begin
            m_ok_reg         <= ok;
            m_where_reg      <= ok ? WHERE_W'(widx) : '0;
            m_count_reg      <= COUNT_W'(ok ? cnt_new : count_reg);
            m_read_value_reg <= signed'(rd);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_ok         = m_ok_reg;
    assign m_where      = m_where_reg;
    assign m_count      = m_count_reg;
    assign m_read_value = m_read_value_reg;

    `ILIR_ASSERT_NEVER(a_count_bound, count_reg > CNT_W'(LIST_DEPTH), "entry count beyond depth")
    `ILIR_ASSERT_NEXT(a_count_idle, state_reg == ST_IDLE, $stable(count_reg), "count moved")
    `ILIR_ASSERT_IMPLY(a_where_ok, m_valid && m_ok, COUNT_W'(m_where) <= m_count, "bad where")

endmodule
`default_nettype wire

>>> src/ilir_cell.sv
// One list cell: holds a single entry and its registered match flag.
// Shifts from either neighbour on insert/remove. Depends on ilir_pkg.
`default_nettype none
module ilir_cell (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic [ilir_pkg::IDX_W-1:0] cell_idx,
    input  wire ilir_pkg::ilir_ctrl_t       ctrl,
    input  wire logic [ilir_pkg::WORD_W-1:0] left_entry,
    input  wire logic [ilir_pkg::WORD_W-1:0] right_entry,
    output logic [ilir_pkg::WORD_W-1:0]     entry,
    output logic                            match
);
    import ilir_pkg::*;

    logic [WORD_W-1:0] entry_reg, entry_next;
    logic              match_reg, match_next;

    always_comb begin
        entry_next = entry_reg;
        match_next = match_reg;
        unique case (ctrl.op)
            OP_CMP: begin
                match_next = (entry_reg == ctrl.value) && (CNT_W'(cell_idx) < ctrl.count);
            end
            OP_INS: begin
                if (cell_idx > ctrl.sel) begin
                    entry_next = left_entry;
                end else if (cell_idx == ctrl.sel) begin
                    entry_next = ctrl.value;
                end
            end
            OP_REM: begin
                if (cell_idx >= ctrl.sel) begin
                    entry_next = right_entry;
                end
            end
            OP_WR: begin
                if (cell_idx == ctrl.sel) begin
                    entry_next = ctrl.value;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else begin
            match_reg <= match_next;
        end
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule
`default_nettype wire

>>> dv/list_shadow_checker.sv
// Checker for the indexed list: keeps a shadow copy of the list, predicts each result
// and compares it with what the block returns. Depends on ilir_pkg.
module list_shadow_checker (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    input  wire logic                                s_ready,
    input  wire logic [ilir_pkg::CMD_W-1:0]          s_cmd,
    input  wire logic signed [ilir_pkg::WORD_W-1:0]  s_value,
    input  wire logic [ilir_pkg::POS_W-1:0]          s_position,
    input  wire logic                                m_valid,
    input  wire logic                                m_ready,
    input  wire logic                                m_ok,
    input  wire logic [ilir_pkg::WHERE_W-1:0]        m_where,
    input  wire logic [ilir_pkg::COUNT_W-1:0]        m_count,
    input  wire logic signed [ilir_pkg::WORD_W-1:0]  m_read_value,
    output int                                       errors,
    output int                                       pending,
    output int                                       checked,
    output int                                       refused,
    output int                                       peak
);
    timeunit 1ns;
    timeprecision 1ps;
    import ilir_pkg::*;

    typedef struct packed {
        logic                     ok;
        logic [WHERE_W-1:0]       where;
        logic [COUNT_W-1:0]       count;
        logic signed [WORD_W-1:0] read_value;
    } list_result_t;

    logic [WORD_W-1:0] shadow_words[LIST_DEPTH];
    int                shadow_fill = 0;
    list_result_t      expected_results[$];

    function automatic list_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                   input logic [WORD_W-1:0] word,
                                                   input logic [POS_W-1:0] pos);
        list_result_t res;
        int           hit;
        res = '0;
        hit = -1;
        case (cmd)
            CMD_INSERT: begin
                if (shadow_fill < LIST_DEPTH && int'(pos) <= shadow_fill) begin
                    for (int i = shadow_fill; i > int'(pos); i--)
                        shadow_words[i] = shadow_words[i - 1];
                    shadow_words[pos[IDX_W-1:0]] = word;
                    shadow_fill++;
                    res.ok    = 1'b1;
                    res.where = WHERE_W'(pos);
                end
            end
            CMD_REMOVE: begin
                // only live entries are searched
                for (int i = 0; i < shadow_fill && hit < 0; i++)
                    if (shadow_words[i] == word)
                        hit = i;
                if (hit >= 0) begin
                    for (int i = hit; i + 1 < shadow_fill; i++)
                        shadow_words[i] = shadow_words[i + 1];
                    shadow_fill--;
                    res.ok    = 1'b1;
                    res.where = WHERE_W'(hit);
                end
            end
            CMD_APPEND: begin
                if (shadow_fill < LIST_DEPTH) begin
                    shadow_words[shadow_fill] = word;
                    res.where = WHERE_W'(shadow_fill);
                    shadow_fill++;
                    res.ok = 1'b1;
                end
            end
            CMD_READ: begin
                if (int'(pos) < shadow_fill) begin
                    res.read_value = shadow_words[pos[IDX_W-1:0]];
                    res.where      = WHERE_W'(pos);
                    res.ok         = 1'b1;
                end
            end
        endcase
        res.count = COUNT_W'(shadow_fill);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] list check: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d field %s is %0h, expected %0h",
                                      checked, name, got, want));
    endtask

    always @(posedge aclk) begin
        list_result_t want;
        if (!aresetn) begin
            shadow_fill = 0;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result transaction with nothing outstanding");
                end else begin
                    want = expected_results.pop_front();
                    check_field("ok", WORD_W'(m_ok), WORD_W'(want.ok));
                    check_field("where", WORD_W'(m_where), WORD_W'(want.where));
                    check_field("count", WORD_W'(m_count), WORD_W'(want.count));
                    check_field("read_value", unsigned'(m_read_value),
                                unsigned'(want.read_value));
                    checked++;
                    if (!want.ok)
                        refused++;
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(apply_command(s_cmd, s_value, s_position));
                if (shadow_fill > peak)
                    peak = shadow_fill;
            end
        end
        pending = expected_results.size();
    end

endmodule

>>> dv/tb_top.sv
// Top of the indexed list testbench: clock, reset, command stimulus and result back-pressure.
// Depends on ilir_pkg, indexed_list_insert_remove and list_shadow_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ilir_pkg::*;

    localparam int N_ITEMS   = 1250;
    localparam int CYCLE_CAP = 600000;

    typedef enum int {EP_FILL, EP_DRAIN, EP_MIXED, EP_FLOOD} episode_e;

    logic                     aclk       = 1'b0;
    logic                     aresetn    = 1'b0;
    logic                     s_valid    = 1'b0;
    logic                     s_ready;
    logic [CMD_W-1:0]         s_cmd      = CMD_READ;
    logic signed [WORD_W-1:0] s_value    = '0;
    logic [POS_W-1:0]         s_position = '0;
    logic                     m_valid;
    logic                     m_ready    = 1'b0;
    logic                     m_ok;
    logic [WHERE_W-1:0]       m_where;
    logic [COUNT_W-1:0]       m_count;
    logic signed [WORD_W-1:0] m_read_value;

    int errors, pending, checked, refused, peak;
    int cycles   = 0;
    int sent     = 0;
    int per_cmd[4];
    int out_hold = 0;
    bit calm     = 1'b0;

    logic [WORD_W-1:0] word_pool[8];
    logic [WORD_W-1:0] recent_words[$];

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    indexed_list_insert_remove i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_value      (s_value),
        .s_position   (s_position),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ok         (m_ok),
        .m_where      (m_where),
        .m_count      (m_count),
        .m_read_value (m_read_value)
    );

    list_shadow_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_value      (s_value),
        .s_position   (s_position),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ok         (m_ok),
        .m_where      (m_where),
        .m_count      (m_count),
        .m_read_value (m_read_value),
        .errors       (errors),
        .pending      (pending),
        .checked      (checked),
        .refused      (refused),
        .peak         (peak)
    );

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(negedge aclk) begin
        if (out_hold > 0) begin
            m_ready  <= 1'b0;
            out_hold <= out_hold - 1;
        end else begin
            m_ready  <= 1'b1;
            out_hold <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Timed out after %0d cycles with %0d results outstanding", cycles, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] word,
                             input logic [POS_W-1:0] pos);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_cmd      <= cmd;
        s_value    <= word;
        s_position <= pos;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
        sent++;
        per_cmd[cmd]++;
        if (cmd == CMD_INSERT || cmd == CMD_APPEND) begin
            recent_words.push_back(word);
            if (recent_words.size() > 48)
                void'(recent_words.pop_front());
        end
    endtask

    task automatic random_item(input episode_e ep);
        int                r;
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] word;
        logic [POS_W-1:0]  pos;
        r = $urandom_range(0, 99);
        case (ep)
            EP_FILL:  cmd = (r < 45) ? CMD_APPEND : (r < 80) ? CMD_INSERT :
                            (r < 90) ? CMD_READ : CMD_REMOVE;
            EP_DRAIN: cmd = (r < 70) ? CMD_REMOVE : (r < 85) ? CMD_READ :
                            (r < 93) ? CMD_INSERT : CMD_APPEND;
            EP_FLOOD: cmd = (r < 60) ? CMD_APPEND : (r < 90) ? CMD_INSERT : CMD_READ;
            default:  cmd = (r < 25) ? CMD_INSERT : (r < 50) ? CMD_REMOVE :
                            (r < 75) ? CMD_APPEND : CMD_READ;
        endcase
        // removal keys mostly come from recently stored words so that they hit
        r = $urandom_range(0, 99);
        if (cmd == CMD_REMOVE && r < 75 && recent_words.size() > 0)
            word = recent_words[$urandom_range(0, recent_words.size() - 1)];
        else if (r < 85)
            word = word_pool[$urandom_range(0, 7)];
        else
            word = $urandom;
        r = $urandom_range(0, 99);
        if (ep == EP_FLOOD && cmd == CMD_INSERT)
            pos = '0;
        else if (r < 55)
            pos = POS_W'($urandom_range(0, 8));
        else if (r < 85)
            pos = POS_W'($urandom_range(0, 33));
        else
            pos = POS_W'($urandom_range(0, 63));
        send_item(cmd, word, pos);
    endtask

    initial begin
        episode_e ep;
        int       len;
        word_pool = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                      $urandom, $urandom, $urandom, $urandom};
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty list, bad positions, extremes of value, duplicates, stale slots
        send_item(CMD_READ,   32'h0000_0000, 6'd0);
        send_item(CMD_REMOVE, 32'h0000_0000, 6'd0);
        send_item(CMD_INSERT, 32'h0000_0001, 6'd1);
        send_item(CMD_INSERT, 32'h8000_0000, 6'd0);
        send_item(CMD_APPEND, 32'h7FFF_FFFF, 6'd63);
        send_item(CMD_INSERT, 32'hFFFF_FFFF, 6'd1);
        send_item(CMD_INSERT, 32'h0000_0000, 6'd3);
        send_item(CMD_INSERT, 32'h5A5A_A5A5, 6'd63);
        send_item(CMD_READ,   32'h0000_0000, 6'd3);
        send_item(CMD_READ,   32'h0000_0000, 6'd4);
        send_item(CMD_READ,   32'hFFFF_FFFF, 6'd63);
        send_item(CMD_READ,   32'h0000_0000, 6'd0);
        send_item(CMD_APPEND, 32'hFFFF_FFFF, 6'd0);
        send_item(CMD_REMOVE, 32'hFFFF_FFFF, 6'd0);
        send_item(CMD_REMOVE, 32'h1234_5678, 6'd0);
        send_item(CMD_REMOVE, 32'h0000_0000, 6'd0);
        send_item(CMD_REMOVE, 32'h7FFF_FFFF, 6'd0);
        send_item(CMD_READ,   32'h0000_0000, 6'd2);
        send_item(CMD_REMOVE, 32'hFFFF_FFFF, 6'd0);
        send_item(CMD_REMOVE, 32'h8000_0000, 6'd0);
        send_item(CMD_REMOVE, 32'h8000_0000, 6'd0);

        while (sent < N_ITEMS) begin
            ep   = episode_e'($urandom_range(0, 3));
            calm = ($urandom_range(0, 3) == 0);
            len  = (ep == EP_FLOOD) ? 40 : $urandom_range(30, 50);
            repeat (len)
                random_item(ep);
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        while (pending != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);

        $display("Sent %0d commands: %0d insert, %0d remove, %0d append, %0d read",
                 sent, per_cmd[CMD_INSERT], per_cmd[CMD_REMOVE], per_cmd[CMD_APPEND],
                 per_cmd[CMD_READ]);
        $display("Checked %0d results, %0d refused; list reached %0d of %0d entries",
                 checked, refused, peak, LIST_DEPTH);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
